@@ rtl/evm_stk_pkg.sv @@
// Shared types and constants for the operand stack core.
// Operation and status codes, fixed field widths, reset values.
// No dependencies.
`default_nettype none

package evm_stk_pkg;

  // Widths of the transfer fields; these do not follow the parameters.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned LEVEL_W = 11;
  localparam int unsigned STAT_W  = 2;

  localparam logic [LEVEL_W-1:0] THRESH_RST = 11'd900;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_DUP  = 2'd2;
  localparam logic [OP_W-1:0] OP_SWAP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_SHALLOW   = 2'd3;

  // Address unit selections, all relative to the current depth.
  typedef enum logic [1:0] {
    AGU_NEXT  = 2'd0,  // depth: first free slot
    AGU_TOP   = 2'd1,  // depth - 1: top entry
    AGU_DIST  = 2'd2,  // depth - n: dup source
    AGU_UNDER = 2'd3   // depth - n - 1: swap partner
  } agu_sel_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/evm_operand_stack_core.sv @@
// Operand stack core: push, pop, dup n, swap n on a bounded stack of words.
// Push and any failed operation go from execute straight to done; pop and dup wait
// for read data, and swap makes four accesses through the single memory port.
// One item is in flight; input waits until the result is in the output register.
// Reset clears depth, peak depth and control state and sets the threshold to 900;
// the entry memory is not cleared, since only written entries are ever read.
// Depends on evm_stk_pkg, evm_stk_agu and evm_stk_mem.
`default_nettype none

module evm_operand_stack_core import evm_stk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned WORD_BITS   = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration: near-full threshold, written without handshake.
  input  wire logic               cfg_we_i,
  input  wire logic [LEVEL_W-1:0] cfg_wdata_i,
  // Operation channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [DATA_W-1:0]  push_word_i,
  input  wire logic [DIST_W-1:0]  distance_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [DATA_W-1:0]       pop_word_o,
  output logic [STAT_W-1:0]       status_o,
  output logic [LEVEL_W-1:0]      level_o,
  output logic [LEVEL_W-1:0]      peak_level_o,
  output logic                    near_full_o
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = (LW > LEVEL_W) ? LW : LEVEL_W;

  // Sequencer states. A swap walks through every state but the pop and dup ones;
  // the two reads and two writes each use the memory port in a state of their own.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] S_EXEC = 3'd1;  // decode, check bounds, first access
  localparam logic [2:0] S_POPW = 3'd2;  // popped word arrives from memory
  localparam logic [2:0] S_DUPW = 3'd3;  // dup source arrives, written on top
  localparam logic [2:0] S_SWR2 = 3'd4;  // top arrives, read swap partner
  localparam logic [2:0] S_SWW1 = 3'd5;  // partner arrives, written to top
  localparam logic [2:0] S_SWW2 = 3'd6;  // old top written to partner slot
  localparam logic [2:0] S_DONE = 3'd7;  // hand the result to the output register

  logic [2:0]           state_q, state_d;
  logic [LW-1:0]        fill_q, fill_d;
  logic [LW-1:0]        hw_q, hw_d;
  logic [LEVEL_W-1:0]   thresh_q;

  // Captured operation; payload registers without reset.
  logic [OP_W-1:0]      op_q;
  logic [WORD_BITS-1:0] word_q;
  logic [DIST_W-1:0]    dist_q;

  logic [WORD_BITS-1:0] tmp_q, tmp_d;
  logic [STAT_W-1:0]    rstat_q, rstat_d;
  logic [WORD_BITS-1:0] rpop_q, rpop_d;

  // Output register, so a waiting result does not hold up the sequencer state.
  logic                 out_valid_q;
  logic [DATA_W-1:0]    out_pop_q;
  logic [STAT_W-1:0]    out_stat_q;
  logic [LEVEL_W-1:0]   out_level_q;
  logic [LEVEL_W-1:0]   out_peak_q;
  logic                 out_nf_q;
  logic                 out_load;

  agu_sel_e             agu_sel;
  logic [AW-1:0]        mem_addr;
  mem_ctrl_t            mem_ctrl;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  logic                 in_xfer;
  logic                 full;
  logic                 empty;
  logic [LW-1:0]        fill_inc;
  logic [CW-1:0]        fill_c;
  logic [CW-1:0]        dist_c;
  logic [CW-1:0]        hw_c;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign full     = (fill_q == LW'(STACK_DEPTH));
  assign empty    = (fill_q == '0);
  assign fill_inc = fill_q + LW'(1);
  assign fill_c   = CW'(fill_q);
  assign dist_c   = CW'(dist_q);
  assign hw_c     = CW'(hw_q);

  evm_stk_agu #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_agu (
    .fill_i (fill_q),
    .dist_i (dist_q),
    .sel_i  (agu_sel),
    .addr_o (mem_addr)
  );

  evm_stk_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // The sequencer issues at most one memory access per cycle. Bounds checks happen
  // in the execute state before any access, so a failed operation leaves the stack
  // untouched and goes straight to the result.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    hw_d      = hw_q;
    tmp_d     = tmp_q;
    rstat_d   = rstat_q;
    rpop_d    = rpop_q;
    agu_sel   = AGU_NEXT;
    mem_ctrl  = '0;
    mem_wdata = word_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        rpop_d  = '0;
        rstat_d = ST_OK;
        state_d = S_DONE;
        unique case (op_q)
          OP_PUSH: begin
            if (full) begin
              rstat_d = ST_OVERFLOW;
            end else begin
              agu_sel        = AGU_NEXT;
              mem_ctrl.wr_en = 1'b1;
              mem_wdata      = word_q;
              fill_d         = fill_inc;
              if (fill_inc > hw_q) begin
                hw_d = fill_inc;
              end
            end
          end
          OP_POP: begin
            if (empty) begin
              rstat_d = ST_UNDERFLOW;
            end else begin
              agu_sel        = AGU_TOP;
              mem_ctrl.rd_en = 1'b1;
              fill_d         = fill_q - LW'(1);
              state_d        = S_POPW;
            end
          end
          OP_DUP: begin
            // The depth check comes before the full check.
            if ((dist_q == '0) || (fill_c < dist_c)) begin
              rstat_d = ST_SHALLOW;
            end else if (full) begin
              rstat_d = ST_OVERFLOW;
            end else begin
              agu_sel        = AGU_DIST;
              mem_ctrl.rd_en = 1'b1;
              state_d        = S_DUPW;
            end
          end
          OP_SWAP: begin
            // A swap at distance zero runs the full sequence on the same slot.
            if (fill_c <= dist_c) begin
              rstat_d = ST_SHALLOW;
            end else begin
              agu_sel        = AGU_TOP;
              mem_ctrl.rd_en = 1'b1;
              state_d        = S_SWR2;
            end
          end
          default: begin
            rstat_d = ST_OK;
          end
        endcase
      end
      S_POPW: begin
        rpop_d  = mem_rdata;
        state_d = S_DONE;
      end
      S_DUPW: begin
        agu_sel        = AGU_NEXT;
        mem_ctrl.wr_en = 1'b1;
        mem_wdata      = mem_rdata;
        fill_d         = fill_inc;
        if (fill_inc > hw_q) begin
          hw_d = fill_inc;
        end
        state_d = S_DONE;
      end
      S_SWR2: begin
        tmp_d          = mem_rdata;
        agu_sel        = AGU_UNDER;
        mem_ctrl.rd_en = 1'b1;
        state_d        = S_SWW1;
      end
      S_SWW1: begin
        agu_sel        = AGU_TOP;
        mem_ctrl.wr_en = 1'b1;
        mem_wdata      = mem_rdata;
        state_d        = S_SWW2;
      end
      S_SWW2: begin
        agu_sel        = AGU_UNDER;
        mem_ctrl.wr_en = 1'b1;
        mem_wdata      = tmp_q;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      hw_q        <= '0;
      thresh_q    <= THRESH_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      hw_q        <= hw_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= operation_i;
      word_q <= push_word_i[WORD_BITS-1:0];
      dist_q <= distance_i;
    end
    tmp_q   <= tmp_d;
    rstat_q <= rstat_d;
    rpop_q  <= rpop_d;
    if (out_load) begin
      out_pop_q   <= DATA_W'(rpop_q);
      out_stat_q  <= rstat_q;
      out_level_q <= fill_c[LEVEL_W-1:0];
      out_peak_q  <= hw_c[LEVEL_W-1:0];
      out_nf_q    <= (fill_c > CW'(thresh_q));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pop_word_o   = out_pop_q;
  assign status_o     = out_stat_q;
  assign level_o      = out_level_q;
  assign peak_level_o = out_peak_q;
  assign near_full_o  = out_nf_q;

endmodule

`default_nettype wire

@@ rtl/evm_stk_agu.sv @@
// Address unit of the operand stack: one adder forms every entry address.
// Depends on evm_stk_pkg.
`default_nettype none

module evm_stk_agu import evm_stk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  wire logic [$clog2(STACK_DEPTH+1)-1:0] fill_i,
  input  wire logic [DIST_W-1:0]                dist_i,
  input  wire agu_sel_e                         sel_i,
  output logic [$clog2(STACK_DEPTH)-1:0]        addr_o
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = (LW > LEVEL_W) ? LW : LEVEL_W;

  logic [CW-1:0] fill_c;
  logic [CW-1:0] dist_c;
  logic [CW-1:0] off;
  logic          cin;
  logic [CW-1:0] sum;

  assign fill_c = CW'(fill_i);
  assign dist_c = CW'(dist_i);

  // Subtraction is done as addition of the inverted operand plus carry in.
  always_comb begin
    unique case (sel_i)
      AGU_NEXT: begin
        off = '0;
        cin = 1'b0;
      end
      AGU_TOP: begin
        off = '1;
        cin = 1'b0;
      end
      AGU_DIST: begin
        off = ~dist_c;
        cin = 1'b1;
      end
      AGU_UNDER: begin
        off = ~dist_c;
        cin = 1'b0;
      end
      default: begin
        off = '0;
        cin = 1'b0;
      end
    endcase
  end

  assign sum    = fill_c + off + CW'(cin);
  assign addr_o = sum[AW-1:0];

endmodule

`default_nettype wire

@@ rtl/evm_stk_mem.sv @@
// Entry storage of the operand stack: single port, registered read data.
// Depends on evm_stk_pkg.
`default_nettype none

module evm_stk_mem import evm_stk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned WORD_BITS   = 64
) (
  input  wire logic                           clk_i,
  input  wire mem_ctrl_t                      ctrl_i,
  input  wire logic [$clog2(STACK_DEPTH)-1:0] addr_i,
  input  wire logic [WORD_BITS-1:0]           wdata_i,
  output logic [WORD_BITS-1:0]                rdata_o
);

  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/evm_stk_chk.sv @@
// Port-level checker for the operand stack core and its bind statement.
// Depends on evm_stk_pkg and evm_operand_stack_core.
`default_nettype none

module evm_stk_chk import evm_stk_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [DATA_W-1:0]  pop_word_o,
  input wire logic [STAT_W-1:0]  status_o,
  input wire logic [LEVEL_W-1:0] level_o
);

  // A stalled result keeps its word and status.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pop_word_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Only one item is in flight: the block is busy right after a transfer.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // Any failed operation reports a zero word.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (pop_word_o == '0))
    else $error("nonzero word with failing status");

  // Underflow only happens on an empty stack, which stays empty.
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_UNDERFLOW) |-> (level_o == '0))
    else $error("underflow reported with nonzero depth");

endmodule

bind evm_operand_stack_core evm_stk_chk u_chk (.*);

`default_nettype wire

@@ test/tb_evm_operand_stack_core.sv @@
// Self-checking testbench for evm_operand_stack_core: push, pop, dup and swap on the stack.
// A directed table comes first, then random runs that fill the stack and drain it again.
// Depends on evm_stk_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_evm_operand_stack_core;
  import evm_stk_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned STACK_DEPTH   = 1024;
  localparam int unsigned DIST_MAX      = (1 << DIST_W) - 1;
  // Quiet time after the last owed result; it outlasts the longest operation of the core.
  localparam int unsigned SETTLE_CYCLES = 12;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned DIR_ROWS      = 25;

  // One result transfer, field for field as it leaves the core.
  typedef struct packed {
    logic [DATA_W-1:0]  pop_word;
    logic [STAT_W-1:0]  status;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak_level;
    logic               near_full;
  } stack_result_t;

  // One row of the directed table. When typed is set, result holds the expected
  // result written out by hand; otherwise the mirror below computes it.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] word;
    logic [DIST_W-1:0] distance;
    logic              typed;
    stack_result_t     result;
  } stim_row_t;

  localparam stack_result_t NO_RESULT = '0;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [LEVEL_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    operation_i = OP_PUSH;
  logic [DATA_W-1:0]  push_word_i = '0;
  logic [DIST_W-1:0]  distance_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DATA_W-1:0]  pop_word_o;
  logic [STAT_W-1:0]  status_o;
  logic [LEVEL_W-1:0] level_o;
  logic [LEVEL_W-1:0] peak_level_o;
  logic               near_full_o;

  // Mirror of the stack contents, depth, peak depth and near-full threshold.
  logic [DATA_W-1:0] stack_words [STACK_DEPTH];
  int unsigned       stack_fill = 0;
  int unsigned       stack_peak = 0;
  int unsigned       warn_level = THRESH_RST;

  // Results the core still owes, oldest first.
  stack_result_t     pending_results [$];

  int unsigned       error_count   = 0;
  int unsigned       items_sent    = 0;
  int unsigned       idle_cycles   = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;

  evm_operand_stack_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .push_word_i  (push_word_i),
    .distance_i   (distance_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pop_word_o   (pop_word_o),
    .status_o     (status_o),
    .level_o      (level_o),
    .peak_level_o (peak_level_o),
    .near_full_o  (near_full_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Pushes a word onto the mirror, shared by push and by a dup that passes its
  // depth check. A full stack refuses the word and reports overflow.
  function automatic logic [STAT_W-1:0] push_onto_mirror(logic [DATA_W-1:0] word);
    if (stack_fill >= STACK_DEPTH) begin
      return ST_OVERFLOW;
    end
    stack_words[stack_fill] = word;
    stack_fill++;
    if (stack_fill > stack_peak) begin
      stack_peak = stack_fill;
    end
    return ST_OK;
  endfunction

  // Applies one operation to the mirror and returns the result the core must give.
  function automatic stack_result_t predict_stack_result(logic [OP_W-1:0] op,
                                                         logic [DATA_W-1:0] word,
                                                         logic [DIST_W-1:0] distance);
    stack_result_t     res;
    logic [DATA_W-1:0] held;
    int unsigned       n;
    res        = '0;
    res.status = ST_OK;
    n          = distance;
    case (op)
      OP_PUSH: begin
        res.status = push_onto_mirror(word);
      end
      OP_POP: begin
        // An empty stack answers underflow with a zero word.
        if (stack_fill == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          stack_fill--;
          res.pop_word = stack_words[stack_fill];
        end
      end
      OP_DUP: begin
        // Distance zero, or a source below the bottom, leaves the stack alone.
        if (n == 0 || stack_fill < n) begin
          res.status = ST_SHALLOW;
        end else begin
          res.status = push_onto_mirror(stack_words[stack_fill - n]);
        end
      end
      OP_SWAP: begin
        // Distance zero swaps the top with itself, which is a legal no-op.
        if (stack_fill < n + 1) begin
          res.status = ST_SHALLOW;
        end else begin
          held = stack_words[stack_fill - 1];
          stack_words[stack_fill - 1] = stack_words[stack_fill - n - 1];
          stack_words[stack_fill - n - 1] = held;
        end
      end
    endcase
    res.level      = LEVEL_W'(stack_fill);
    res.peak_level = LEVEL_W'(stack_peak);
    res.near_full  = (stack_fill > warn_level);
    return res;
  endfunction

  // Mostly random words, with the all-ones and all-zeros patterns mixed in.
  function automatic logic [DATA_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return '1;
    end
    if (pick == 1) begin
      return '0;
    end
    return {$urandom, $urandom};
  endfunction

  // Chooses a dup or swap distance. Reach is the largest distance that still
  // lands inside the stack; zero, one step too deep and fully random values are
  // mixed in so that the shallow cases keep showing up.
  function automatic logic [DIST_W-1:0] pick_distance(int unsigned reach);
    int unsigned pick;
    int unsigned hi;
    pick = $urandom_range(0, 99);
    hi   = (reach > DIST_MAX) ? DIST_MAX : reach;
    if (pick < 12) begin
      return '0;
    end
    if (pick < 27) begin
      return DIST_W'($urandom_range(0, DIST_MAX));
    end
    if (pick < 35) begin
      return DIST_W'((reach >= DIST_MAX) ? DIST_MAX : reach + 1);
    end
    if (hi == 0) begin
      return DIST_W'($urandom_range(0, 3));
    end
    if (pick < 70) begin
      return DIST_W'($urandom_range(1, (hi < 8) ? hi : 8));
    end
    return DIST_W'($urandom_range(1, hi));
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Presents one operation and holds it until the core takes it. The call starts
  // and ends on a rising edge, so back-to-back calls keep valid high without a
  // glitch. Idle rates follow the item count: sender-light and receiver-heavy
  // first, then the reverse, then no idling at all.
  task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] word,
                           logic [DIST_W-1:0] distance, logic typed, stack_result_t fixed);
    stack_result_t predicted;
    if (items_sent < 650) begin
      send_idle_pct = 9;
      recv_idle_pct = 60;
    end else if (items_sent < 1300) begin
      send_idle_pct = 60;
      recv_idle_pct = 9;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    push_word_i <= word;
    distance_i  <= distance;
    do @(posedge clk_i); while (!in_ready_o);
    // The transfer happened at this edge; the mirror moves along with the core.
    predicted = predict_stack_result(op, word, distance);
    pending_results.push_back(typed ? fixed : predicted);
    items_sent++;
  endtask

  // Drops valid, waits for every owed result and lets the pipeline go quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The threshold is only changed while the core is idle.
  task automatic write_threshold(logic [LEVEL_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    warn_level   = value;
  endtask

  // Random run with a given operation mix; swap takes what the other three leave.
  // With until_full set, only items sent onto a full stack count, so the run
  // first climbs to the top and then keeps pressing on it.
  task automatic run_ops(int unsigned count, int unsigned push_pct, int unsigned pop_pct,
                         int unsigned dup_pct, bit until_full);
    int unsigned     done;
    int unsigned     pick;
    int unsigned     reach;
    logic [OP_W-1:0] op;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        op = OP_PUSH;
      end else if (pick < push_pct + pop_pct) begin
        op = OP_POP;
      end else if (pick < push_pct + pop_pct + dup_pct) begin
        op = OP_DUP;
      end else begin
        op = OP_SWAP;
      end
      if (op == OP_SWAP) begin
        reach = (stack_fill == 0) ? 0 : stack_fill - 1;
      end else begin
        reach = stack_fill;
      end
      if (!until_full || stack_fill >= STACK_DEPTH) begin
        done++;
      end
      send_item(op, random_word(), pick_distance(reach), 1'b0, NO_RESULT);
    end
  endtask

  // Result side: every accepted result is matched against the oldest expectation.
  // Ready is redrawn each cycle from the current idle rate.
  always @(posedge clk_i) begin
    stack_result_t oldest;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pop_word %0h status %0h",
                 $time, pop_word_o, status_o);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("pop_word", oldest.pop_word, pop_word_o);
        check_field("status", oldest.status, status_o);
        check_field("level", oldest.level, level_o);
        check_field("peak_level", oldest.peak_level, peak_level_o);
        check_field("near_full", oldest.near_full, near_full_o);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("evm_operand_stack_core verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_table [DIR_ROWS];
    // Directed table, run with the reset threshold. It starts on an empty stack,
    // builds three words, probes dup and swap at and just past the depth, then
    // empties the stack and underflows again with the peak still remembered.
    dir_table = '{
      '{OP_POP,  64'h0,                   10'd0,    1'b1,
        '{64'h0, ST_UNDERFLOW, 11'd0, 11'd0, 1'b0}},
      '{OP_DUP,  64'hDEAD_BEEF_0000_0001, 10'd0,    1'b1,
        '{64'h0, ST_SHALLOW,   11'd0, 11'd0, 1'b0}},
      '{OP_SWAP, 64'h0,                   10'd0,    1'b1,
        '{64'h0, ST_SHALLOW,   11'd0, 11'd0, 1'b0}},
      '{OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0,    1'b1,
        '{64'h0, ST_OK,        11'd1, 11'd1, 1'b0}},
      '{OP_PUSH, 64'h0,                   10'd1023, 1'b1,
        '{64'h0, ST_OK,        11'd2, 11'd2, 1'b0}},
      '{OP_PUSH, 64'hA5A5_A5A5_5A5A_5A5A, 10'd5,    1'b1,
        '{64'h0, ST_OK,        11'd3, 11'd3, 1'b0}},
      '{OP_DUP,  64'h0,                   10'd0,    1'b1,
        '{64'h0, ST_SHALLOW,   11'd3, 11'd3, 1'b0}},
      '{OP_DUP,  64'h0,                   10'd4,    1'b1,
        '{64'h0, ST_SHALLOW,   11'd3, 11'd3, 1'b0}},
      '{OP_DUP,  64'h0,                   10'd3,    1'b0, NO_RESULT},
      '{OP_SWAP, 64'h0,                   10'd0,    1'b1,
        '{64'h0, ST_OK,        11'd4, 11'd4, 1'b0}},
      '{OP_SWAP, 64'h0,                   10'd4,    1'b1,
        '{64'h0, ST_SHALLOW,   11'd4, 11'd4, 1'b0}},
      '{OP_SWAP, 64'hFFFF_0000_FFFF_0000, 10'd3,    1'b0, NO_RESULT},
      '{OP_DUP,  64'h0,                   10'd1,    1'b0, NO_RESULT},
      '{OP_PUSH, 64'h8000_0000_0000_0001, 10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b0, NO_RESULT},
      '{OP_POP,  64'h0,                   10'd0,    1'b1,
        '{64'h0, ST_UNDERFLOW, 11'd0, 11'd6, 1'b0}},
      '{OP_PUSH, 64'h0123_4567_89AB_CDEF, 10'd1023, 1'b1,
        '{64'h0, ST_OK,        11'd1, 11'd6, 1'b0}},
      '{OP_DUP,  64'h0,                   10'd1023, 1'b1,
        '{64'h0, ST_SHALLOW,   11'd1, 11'd6, 1'b0}},
      '{OP_SWAP, 64'h0,                   10'd1023, 1'b1,
        '{64'h0, ST_SHALLOW,   11'd1, 11'd6, 1'b0}},
      '{OP_POP,  64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b0, NO_RESULT}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      send_item(dir_table[i].op, dir_table[i].word, dir_table[i].distance,
                dir_table[i].typed, dir_table[i].result);
    end

    // Threshold zero: any nonempty stack is near full. The mix hovers near the
    // bottom so that underflow and shallow dup and swap come up often.
    write_threshold('0);
    run_ops(150, 35, 40, 15, 1'b0);

    // A small threshold that the depth crosses back and forth.
    write_threshold(LEVEL_W'($urandom_range(1, 40)));
    run_ops(150, 45, 30, 15, 1'b0);

    // Threshold at the depth limit: the flag must stay low all the way up. The
    // climb ends with pushes and dups pressing on a full stack.
    write_threshold(LEVEL_W'(STACK_DEPTH));
    run_ops(40, 80, 3, 12, 1'b1);

    // One below the limit: only a full stack raises the flag.
    write_threshold(LEVEL_W'(STACK_DEPTH - 1));
    run_ops(12, 60, 10, 20, 1'b0);

    // Mostly pops, taking the depth down through the threshold.
    write_threshold(11'd1000);
    run_ops(450, 8, 80, 6, 1'b0);

    // The largest value the register holds.
    write_threshold('1);
    run_ops(60, 40, 30, 15, 1'b0);

    drain_results();
    if (error_count == 0) begin
      $display("evm_operand_stack_core verification clean");
    end else begin
      $display("evm_operand_stack_core verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/evm_stk_pkg.sv
rtl/evm_stk_agu.sv
rtl/evm_stk_mem.sv
rtl/evm_operand_stack_core.sv
rtl/evm_stk_chk.sv
test/tb_evm_operand_stack_core.sv
